FILE: rtl/fjcs_pkg.sv
// Package: shared types and constants of the feeder jam-clear sequencer.
`default_nettype none

package fjcs_pkg;

	localparam int TICK_COUNT_WIDTH_DEF = 16;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int SPEED_W     = 15;
	localparam int RATIO_W     = 8;
	localparam int LIMIT_W     = 16;
	localparam int VALUE_W     = 16;
	localparam int DELAY_W     = 10;

	localparam logic [DELAY_W-1:0] CEASE_HOLD = DELAY_W'(100);
	localparam logic [DELAY_W-1:0] CEASE_MAX  = DELAY_W'(1000);

	localparam logic [7:0] MODE_CEASE      = 8'd0;
	localparam logic [7:0] MODE_CONTINUOUS = 8'd1;
	localparam logic [7:0] LID_OPEN_CODE   = 8'd1;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_FLYWHEEL_SPEED    = 3'd0,
		CFG_FEEDER_SPEED      = 3'd1,
		CFG_JAM_SPEED_LIMIT   = 3'd2,
		CFG_JAM_CURRENT_RATIO = 3'd3,
		CFG_STALL_TICKS_LIMIT = 3'd4,
		CFG_CLEAR_TICKS_LIMIT = 3'd5,
		CFG_FLYWHEEL_LAYOUT   = 3'd6
	} cfg_index_t;

	typedef struct packed {
		logic [SPEED_W-1:0] flywheel_speed;
		logic [SPEED_W-1:0] feeder_speed;
		logic [SPEED_W-1:0] jam_speed_limit;
		logic [RATIO_W-1:0] jam_current_ratio;
		logic [LIMIT_W-1:0] stall_ticks_limit;
		logic [LIMIT_W-1:0] clear_ticks_limit;
		logic               flywheel_layout;
	} cfg_t;

endpackage

`default_nettype wire

FILE: rtl/fjcs_if.sv
// Interfaces: tick input channel and result output channel.
`default_nettype none

interface fjcs_tick_if;
	logic               valid;
	logic               ready;
	logic               command_valid;
	logic [7:0]         command_mode;
	logic [7:0]         lid_request;
	logic signed [15:0] feeder_rpm;
	logic signed [15:0] feeder_current;
	logic signed [15:0] feeder_drive;
	logic signed [15:0] left_rpm;
	logic signed [15:0] right_rpm;
	logic signed [15:0] top_rpm;

	modport source (
		output valid, command_valid, command_mode, lid_request, feeder_rpm,
			feeder_current, feeder_drive, left_rpm, right_rpm, top_rpm,
		input  ready
	);
	modport sink (
		input  valid, command_valid, command_mode, lid_request, feeder_rpm,
			feeder_current, feeder_drive, left_rpm, right_rpm, top_rpm,
		output ready
	);
endinterface

interface fjcs_result_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] feeder_target;
	logic signed [15:0] left_target;
	logic signed [15:0] right_target;
	logic signed [15:0] top_target;
	logic               jam_clearing;
	logic               lid_open;
	logic               fire_mode;

	modport source (
		output valid, feeder_target, left_target, right_target, top_target,
			jam_clearing, lid_open, fire_mode,
		input  ready
	);
	modport sink (
		input  valid, feeder_target, left_target, right_target, top_target,
			jam_clearing, lid_open, fire_mode,
		output ready
	);
endinterface

`default_nettype wire

FILE: rtl/fjcs_stall_detect.sv
// Stall: nonzero drive, low speed, current < 0 or small rel. error.
`default_nettype none

module fjcs_stall_detect import fjcs_pkg::*; (
	input  logic signed [VALUE_W-1:0] feeder_rpm,
	input  logic signed [VALUE_W-1:0] feeder_current,
	input  logic signed [VALUE_W-1:0] feeder_drive,
	input  cfg_t                      cfg,
	output logic                      stall
);

	logic signed [VALUE_W:0]   diff;
	logic [VALUE_W:0]          diff_mag;
	logic signed [VALUE_W:0]   rpm_ext;
	logic [VALUE_W:0]          rpm_mag;
	logic signed [VALUE_W+9:0] lhs;
	logic signed [VALUE_W+8:0] prod;
	logic signed [VALUE_W+9:0] rhs;
	logic                      slow;

	always_comb begin
		diff     = {feeder_current[VALUE_W-1], feeder_current}
			- {feeder_drive[VALUE_W-1], feeder_drive};
		diff_mag = diff[VALUE_W] ? (VALUE_W+1)'(0) - diff : diff;
		rpm_ext  = {feeder_rpm[VALUE_W-1], feeder_rpm};
		rpm_mag  = rpm_ext[VALUE_W] ? (VALUE_W+1)'(0) - rpm_ext : rpm_ext;
		slow     = rpm_mag < {2'b00, cfg.jam_speed_limit};
		// |d| * 256 against ratio * current, both exact
		lhs  = {1'b0, diff_mag, 8'h00};
		prod = $signed({1'b0, cfg.jam_current_ratio}) * feeder_current;
		rhs  = {prod[VALUE_W+8], prod};
		stall = 1'b0;
		if (feeder_drive != '0 && slow) begin
			if (!feeder_current[VALUE_W-1] && feeder_current != '0)
				stall = lhs < rhs;
			else if (feeder_current[VALUE_W-1])
				stall = lhs > rhs;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/feeder_jam_clear_sequencer.sv
// Top level: feeder jam-clear sequencer with config port and tick/result channels.
`default_nettype none

// One tick item enters the input register; once the result register is empty
// or being read, its targets, jam state, lid state and fire mode are computed
// against the held state and written to the result register together with the
// state update, so a result passes through the input and result registers
// after the tick handshake; a new tick is accepted every cycle while the
// result side keeps taking items. Configuration registers (written through
// cfg_we/cfg_index/cfg_data) are expected to change only while no tick is in
// flight. Stall and clear tick counters are TICK_COUNT_WIDTH bits wide and
// saturate.
module feeder_jam_clear_sequencer import fjcs_pkg::*; #(
	parameter int TICK_COUNT_WIDTH = TICK_COUNT_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	fjcs_tick_if.sink              tick,
	fjcs_result_if.source          result
);

	localparam int CW   = TICK_COUNT_WIDTH;
	localparam int CMPW = (CW > LIMIT_W) ? CW : LIMIT_W;

	cfg_t cfg_q;

	// input stage
	logic                      valid_s1;
	logic                      command_valid_s1;
	logic [7:0]                command_mode_s1;
	logic [7:0]                lid_request_s1;
	logic signed [VALUE_W-1:0] feeder_rpm_s1;
	logic signed [VALUE_W-1:0] feeder_current_s1;
	logic signed [VALUE_W-1:0] feeder_drive_s1;
	logic signed [VALUE_W-1:0] left_rpm_s1;
	logic signed [VALUE_W-1:0] right_rpm_s1;
	logic signed [VALUE_W-1:0] top_rpm_s1;

	// block state
	logic                      mode_q, jam_q, reverse_q, lid_q;
	logic [CW-1:0]             stall_cnt_q, clear_cnt_q;
	logic [DELAY_W-1:0]        cease_delay_q;
	logic signed [VALUE_W-1:0] feeder_goal_q, wheel_goal_q;

	logic                      mode_n, jam_n, reverse_n, lid_n;
	logic [CW-1:0]             stall_cnt_n, clear_cnt_n;
	logic [DELAY_W-1:0]        cease_delay_n;
	logic signed [VALUE_W-1:0] feeder_goal_n, wheel_goal_n;
	logic signed [VALUE_W-1:0] left_n, right_n, top_n;

	// result register
	logic                      out_valid_q;
	logic signed [VALUE_W-1:0] feeder_target_q, left_target_q, right_target_q, top_target_q;
	logic                      jam_clearing_q, lid_open_q, fire_mode_q;

	logic                      stall;
	logic                      advance;
	logic [VALUE_W:0]          left_mag, right_mag, top_mag;
	logic [VALUE_W+2:0]        wheel_sum;
	logic [VALUE_W+4:0]        sum_x5, speed_x12;
	logic [VALUE_W-1:0]        fly_pos, feed_pos;

	assign advance    = valid_s1 && (!out_valid_q || result.ready);
	assign tick.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FLYWHEEL_SPEED:    cfg_q.flywheel_speed    <= cfg_data[SPEED_W-1:0];
				CFG_FEEDER_SPEED:      cfg_q.feeder_speed      <= cfg_data[SPEED_W-1:0];
				CFG_JAM_SPEED_LIMIT:   cfg_q.jam_speed_limit   <= cfg_data[SPEED_W-1:0];
				CFG_JAM_CURRENT_RATIO: cfg_q.jam_current_ratio <= cfg_data[RATIO_W-1:0];
				CFG_STALL_TICKS_LIMIT: cfg_q.stall_ticks_limit <= cfg_data[LIMIT_W-1:0];
				CFG_CLEAR_TICKS_LIMIT: cfg_q.clear_ticks_limit <= cfg_data[LIMIT_W-1:0];
				CFG_FLYWHEEL_LAYOUT:   cfg_q.flywheel_layout   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			command_valid_s1  <= tick.command_valid;
			command_mode_s1   <= tick.command_mode;
			lid_request_s1    <= tick.lid_request;
			feeder_rpm_s1     <= tick.feeder_rpm;
			feeder_current_s1 <= tick.feeder_current;
			feeder_drive_s1   <= tick.feeder_drive;
			left_rpm_s1       <= tick.left_rpm;
			right_rpm_s1      <= tick.right_rpm;
			top_rpm_s1        <= tick.top_rpm;
		end
	end

	fjcs_stall_detect u_stall (
		.feeder_rpm     (feeder_rpm_s1),
		.feeder_current (feeder_current_s1),
		.feeder_drive   (feeder_drive_s1),
		.cfg            (cfg_q),
		.stall          (stall)
	);

	always_comb begin
		left_mag  = left_rpm_s1[VALUE_W-1]  ? (VALUE_W+1)'(0) - {1'b1, left_rpm_s1}
			: {1'b0, left_rpm_s1};
		right_mag = right_rpm_s1[VALUE_W-1] ? (VALUE_W+1)'(0) - {1'b1, right_rpm_s1}
			: {1'b0, right_rpm_s1};
		top_mag   = top_rpm_s1[VALUE_W-1]   ? (VALUE_W+1)'(0) - {1'b1, top_rpm_s1}
			: {1'b0, top_rpm_s1};
		wheel_sum = (VALUE_W+3)'(left_mag) + (VALUE_W+3)'(right_mag) + (VALUE_W+3)'(top_mag);
		sum_x5    = (VALUE_W+5)'({wheel_sum, 2'b00}) + (VALUE_W+5)'(wheel_sum);
		speed_x12 = (VALUE_W+5)'({cfg_q.flywheel_speed, 3'b000})
			+ (VALUE_W+5)'({cfg_q.flywheel_speed, 2'b00});
		fly_pos   = {1'b0, cfg_q.flywheel_speed};
		feed_pos  = {1'b0, cfg_q.feeder_speed};

		mode_n        = mode_q;
		lid_n         = lid_q;
		jam_n         = jam_q;
		reverse_n     = reverse_q;
		feeder_goal_n = feeder_goal_q;
		wheel_goal_n  = wheel_goal_q;
		cease_delay_n = cease_delay_q;

		if (command_valid_s1) begin
			if (command_mode_s1 == MODE_CEASE || command_mode_s1 == MODE_CONTINUOUS)
				mode_n = command_mode_s1[0];
			lid_n = (lid_request_s1 == LID_OPEN_CODE);
		end

		if (stall) begin
			stall_cnt_n = (&stall_cnt_q) ? stall_cnt_q : stall_cnt_q + CW'(1);
			clear_cnt_n = clear_cnt_q;
		end else begin
			stall_cnt_n = '0;
			clear_cnt_n = (&clear_cnt_q) ? clear_cnt_q : clear_cnt_q + CW'(1);
		end
		if (CMPW'(stall_cnt_n) > CMPW'(cfg_q.stall_ticks_limit)) begin
			jam_n       = 1'b1;
			reverse_n   = !reverse_q;
			clear_cnt_n = '0;
		end
		if (CMPW'(clear_cnt_n) > CMPW'(cfg_q.clear_ticks_limit))
			jam_n = 1'b0;

		if (!mode_n) begin
			jam_n         = 1'b0;
			reverse_n     = 1'b1;
			feeder_goal_n = '0;
			if (cease_delay_q >= CEASE_HOLD)
				wheel_goal_n = '0;
			cease_delay_n = (cease_delay_q >= CEASE_MAX) ? CEASE_MAX
				: cease_delay_q + DELAY_W'(1);
		end else begin
			cease_delay_n = '0;
			if (!jam_n) begin
				wheel_goal_n = fly_pos;
				if (sum_x5 >= speed_x12)
					feeder_goal_n = -feed_pos;
			end else begin
				feeder_goal_n = reverse_n ? -feed_pos : feed_pos;
				wheel_goal_n  = reverse_n ? -fly_pos : fly_pos;
			end
		end

		if (!cfg_q.flywheel_layout) begin
			left_n  = wheel_goal_n;
			right_n = wheel_goal_n;
			top_n   = wheel_goal_n;
		end else begin
			left_n  = -wheel_goal_n;
			right_n = wheel_goal_n;
			top_n   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= 1'b0;
			jam_q         <= 1'b0;
			reverse_q     <= 1'b0;
			lid_q         <= 1'b0;
			stall_cnt_q   <= '0;
			clear_cnt_q   <= '0;
			cease_delay_q <= '0;
			feeder_goal_q <= '0;
			wheel_goal_q  <= '0;
		end else if (advance) begin
			mode_q        <= mode_n;
			jam_q         <= jam_n;
			reverse_q     <= reverse_n;
			lid_q         <= lid_n;
			stall_cnt_q   <= stall_cnt_n;
			clear_cnt_q   <= clear_cnt_n;
			cease_delay_q <= cease_delay_n;
			feeder_goal_q <= feeder_goal_n;
			wheel_goal_q  <= wheel_goal_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			feeder_target_q <= feeder_goal_n;
			left_target_q   <= left_n;
			right_target_q  <= right_n;
			top_target_q    <= top_n;
			jam_clearing_q  <= jam_n;
			lid_open_q      <= lid_n;
			fire_mode_q     <= mode_n;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.feeder_target = feeder_target_q;
	assign result.left_target   = left_target_q;
	assign result.right_target  = right_target_q;
	assign result.top_target    = top_target_q;
	assign result.jam_clearing  = jam_clearing_q;
	assign result.lid_open      = lid_open_q;
	assign result.fire_mode     = fire_mode_q;

endmodule

`default_nettype wire
